// File: src/pmcg_pkg.sv
package pmcg_pkg;

  localparam int NumPots = 8;
  localparam int PotIdxW = 3;
  localparam int SampleW = 10;
  localparam int TimeW = 32;
  localparam int HoldW = 16;
  localparam int ChanW = 4;
  localparam int CcW = 7;
  localparam int StatusW = 8;
  localparam int NumW = SampleW + CcW;

  localparam int PaddrW = 5;
  localparam int PdataW = 32;

  localparam int FifoPtrW = 1;
  localparam int FifoDepth = 2 ** FifoPtrW;

  localparam logic [StatusW-1:0] CcStatus = 8'hB0;
  localparam logic [CcW-1:0] CcMax = 7'd127;

  // register indexes, byte address is 4 times the index
  localparam logic [2:0] RegInMin = 3'd0;
  localparam logic [2:0] RegInMax = 3'd1;
  localparam logic [2:0] RegThreshold = 3'd2;
  localparam logic [2:0] RegHoldMs = 3'd3;
  localparam logic [2:0] RegChannel = 3'd4;
  localparam logic [2:0] RegFirstCtrl = 3'd5;

  localparam logic [SampleW-1:0] RstInMin = 10'd10;
  localparam logic [SampleW-1:0] RstInMax = 10'd1023;
  localparam logic [SampleW-1:0] RstThreshold = 10'd20;
  localparam logic [HoldW-1:0] RstHoldMs = 16'd300;
  localparam logic [ChanW-1:0] RstChannel = 4'd0;
  localparam logic [CcW-1:0] RstFirstCtrl = 7'd1;

  typedef enum logic [1:0] {
    KIND_ZERO,
    KIND_CLAMP,
    KIND_DIV
  } kind_e;

  typedef struct packed {
    logic [SampleW-1:0] in_min;
    logic [SampleW-1:0] in_max;
    logic [SampleW-1:0] change_threshold;
    logic [HoldW-1:0]   hold_ms;
    logic [ChanW-1:0]   midi_channel;
    logic [CcW-1:0]     first_controller;
  } cfg_t;

  typedef struct packed {
    logic [PotIdxW-1:0] pot_index;
    logic [SampleW-1:0] sample;
    logic [TimeW-1:0]   now_ms;
    kind_e              kind;
    logic [NumW-1:0]    num;
    logic [SampleW-1:0] div;
  } item_t;

endpackage

// File: src/pmcg_if.sv
interface pmcg_in_if import pmcg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PotIdxW-1:0] pot_index;
  logic [SampleW-1:0] sample;
  logic [TimeW-1:0]   now_ms;

  modport source (output valid, pot_index, sample, now_ms, input ready);
  modport sink (input valid, pot_index, sample, now_ms, output ready);
endinterface

interface pmcg_out_if import pmcg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status_byte;
  logic [CcW-1:0]     controller_number;
  logic [CcW-1:0]     cc_value;

  modport source (output valid, status_byte, controller_number, cc_value, input ready);
  modport sink (input valid, status_byte, controller_number, cc_value, output ready);
endinterface

// File: src/pmcg_regs.sv
module pmcg_regs import pmcg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[PaddrW-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        RegInMin:     cfg_d.in_min = pwdata[SampleW-1:0];
        RegInMax:     cfg_d.in_max = pwdata[SampleW-1:0];
        RegThreshold: cfg_d.change_threshold = pwdata[SampleW-1:0];
        RegHoldMs:    cfg_d.hold_ms = pwdata[HoldW-1:0];
        RegChannel:   cfg_d.midi_channel = pwdata[ChanW-1:0];
        RegFirstCtrl: cfg_d.first_controller = pwdata[CcW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegInMin:     prdata = {{(PdataW-SampleW){1'b0}}, cfg_q.in_min};
      RegInMax:     prdata = {{(PdataW-SampleW){1'b0}}, cfg_q.in_max};
      RegThreshold: prdata = {{(PdataW-SampleW){1'b0}}, cfg_q.change_threshold};
      RegHoldMs:    prdata = {{(PdataW-HoldW){1'b0}}, cfg_q.hold_ms};
      RegChannel:   prdata = {{(PdataW-ChanW){1'b0}}, cfg_q.midi_channel};
      RegFirstCtrl: prdata = {{(PdataW-CcW){1'b0}}, cfg_q.first_controller};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.in_min           <= RstInMin;
      cfg_q.in_max           <= RstInMax;
      cfg_q.change_threshold <= RstThreshold;
      cfg_q.hold_ms          <= RstHoldMs;
      cfg_q.midi_channel     <= RstChannel;
      cfg_q.first_controller <= RstFirstCtrl;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: src/pmcg_front.sv
module pmcg_front import pmcg_pkg::*; (
  pmcg_in_if.sink in_i,
  input  cfg_t    cfg_i,
  input  logic    full_i,
  output logic    push_o,
  output item_t   item_o
);

  logic [SampleW-1:0] offset;
  logic [SampleW-1:0] span;
  logic [NumW-1:0]    num;
  logic               pot_ok;
  logic               is_zero;
  logic               is_clamp;

  assign in_i.ready = !full_i;
  assign pot_ok     = int'(in_i.pot_index) < NumPots;

  assign offset = in_i.sample - cfg_i.in_min;
  assign span   = cfg_i.in_max - cfg_i.in_min;
  // offset * 127 as offset * 128 - offset
  assign num    = {offset, {CcW{1'b0}}} - {{CcW{1'b0}}, offset};

  assign is_zero  = (cfg_i.in_max <= cfg_i.in_min) || (in_i.sample <= cfg_i.in_min);
  // quotient above 127 exactly when num reaches span * 128
  assign is_clamp = num >= {span, {CcW{1'b0}}};

  always_comb begin
    item_o.pot_index = in_i.pot_index;
    item_o.sample    = in_i.sample;
    item_o.now_ms    = in_i.now_ms;
    item_o.num       = num;
    item_o.div       = span;
    priority if (is_zero) begin
      item_o.kind = KIND_ZERO;
    end else if (is_clamp) begin
      item_o.kind = KIND_CLAMP;
    end else begin
      item_o.kind = KIND_DIV;
    end
  end

  // items for pots that do not exist are taken and dropped
  assign push_o = in_i.valid && in_i.ready && pot_ok;

endmodule

// File: src/pmcg_fifo.sv
module pmcg_fifo import pmcg_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  output logic  valid_o,
  output item_t item_o,
  input  logic  pop_i
);

  item_t               mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoPtrW:0]   count_q, count_d;
  logic                do_push, do_pop;

  assign full_o  = count_q == (FifoPtrW+1)'(FifoDepth);
  assign valid_o = count_q != '0;
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    count_d = count_q;
    unique case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// File: src/pmcg_back.sv
module pmcg_back import pmcg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        valid_i,
  input  item_t       item_i,
  output logic        pop_o,
  pmcg_out_if.source  out_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [PotIdxW-1:0] idx_q;
  logic [SampleW-1:0] sample_q;
  logic [TimeW-1:0]   now_q;
  logic [SampleW-1:0] div_q;
  logic [SampleW-1:0] rem_q, rem_d;
  logic [CcW-1:0]     shift_q, shift_d;
  logic [CcW-1:0]     quo_q, quo_d;
  logic [2:0]         cnt_q;
  logic               moved_q, in_window_q;

  logic [SampleW-1:0] last_sample_q [NumPots];
  logic [CcW-1:0]     last_value_q [NumPots];
  logic [TimeW-1:0]   move_time_q [NumPots];

  logic               out_valid_q;
  logic [StatusW-1:0] out_status_q;
  logic [CcW-1:0]     out_ctrl_q;
  logic [CcW-1:0]     out_value_q;

  logic [SampleW-1:0] ref_sample;
  logic [SampleW-1:0] abs_diff;
  logic               moved;
  logic [TimeW-1:0]   elapsed_old;
  logic               in_window;
  logic [SampleW:0]   trial;
  logic               ge;
  logic               out_free;
  logic               emit;
  logic               finish;

  // movement and hold window checks against the state left by the last item
  assign ref_sample  = last_sample_q[item_i.pot_index];
  assign abs_diff    = (item_i.sample >= ref_sample) ? item_i.sample - ref_sample
                                                     : ref_sample - item_i.sample;
  assign moved       = abs_diff > cfg_i.change_threshold;
  assign elapsed_old = item_i.now_ms - move_time_q[item_i.pot_index];
  assign in_window   = moved ? (cfg_i.hold_ms != '0)
                             : (elapsed_old < {{(TimeW-HoldW){1'b0}}, cfg_i.hold_ms});

  assign pop_o = (state_q == StIdle) && valid_i;

  // one quotient bit per cycle, remainder stays below the divisor
  assign trial = {rem_q, shift_q[CcW-1]};
  assign ge    = trial >= {1'b0, div_q};

  assign out_free = !out_valid_q || out_o.ready;
  assign emit     = in_window_q && (quo_q != last_value_q[idx_q]);
  assign finish   = (state_q == StEmit) && (!emit || out_free);

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    shift_d = shift_q;
    quo_d   = quo_q;
    unique case (state_q)
      StIdle: begin
        if (valid_i) begin
          rem_d   = item_i.num[NumW-1:CcW];
          shift_d = item_i.num[CcW-1:0];
          unique case (item_i.kind)
            KIND_ZERO:  begin quo_d = '0;    state_d = StEmit; end
            KIND_CLAMP: begin quo_d = CcMax; state_d = StEmit; end
            KIND_DIV:   begin quo_d = '0;    state_d = StDiv;  end
            default:    begin quo_d = '0;    state_d = StEmit; end
          endcase
        end
      end
      StDiv: begin
        rem_d   = ge ? SampleW'(trial - {1'b0, div_q}) : trial[SampleW-1:0];
        shift_d = {shift_q[CcW-2:0], 1'b0};
        quo_d   = {quo_q[CcW-2:0], ge};
        if (cnt_q == 3'(CcW - 1)) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (finish) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumPots; i++) begin
        last_sample_q[i] <= '0;
        last_value_q[i]  <= '0;
        move_time_q[i]   <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == StDiv) begin
        cnt_q <= cnt_q + 1'b1;
      end else begin
        cnt_q <= '0;
      end
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (finish) begin
        if (moved_q) begin
          move_time_q[idx_q] <= now_q;
        end
        if (emit) begin
          last_sample_q[idx_q] <= sample_q;
          last_value_q[idx_q]  <= quo_q;
          out_valid_q          <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    shift_q <= shift_d;
    quo_q   <= quo_d;
    if (pop_o) begin
      idx_q       <= item_i.pot_index;
      sample_q    <= item_i.sample;
      now_q       <= item_i.now_ms;
      div_q       <= item_i.div;
      moved_q     <= moved;
      in_window_q <= in_window;
    end
    if (finish && emit) begin
      out_status_q <= CcStatus | {{(StatusW-ChanW){1'b0}}, cfg_i.midi_channel};
      out_ctrl_q   <= cfg_i.first_controller + CcW'(idx_q);
      out_value_q  <= quo_q;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.status_byte       = out_status_q;
  assign out_o.controller_number = out_ctrl_q;
  assign out_o.cc_value          = out_value_q;

endmodule

// File: src/pot_to_midi_cc_gate_core.sv
// potentiometer to control-change gate
// in_i carries one sample per item: pot_index, 10-bit sample and a free-running
// millisecond timestamp now_ms. out_o carries one control-change message
// (status_byte, controller_number, cc_value) for an item that passes the gate,
// and nothing for one that does not.
// the apb port holds the mapping range, movement threshold, hold window,
// channel and first controller number; write it only while the block is idle.
// the front maps the sample range and classifies each item into a two-entry
// queue; the back runs a bit-serial divider, one quotient bit per cycle, then
// checks and updates the per-pot state.
// an item is popped in the idle state, passes through the seven divider steps
// only when a division is needed, and its message is placed in the output
// register in the emit state; the back handles one item at a time and takes no
// new item until it is through with the last one.
// reset restores the register defaults and clears all per-pot state at once.
// when the receiver stalls, the message waits in the output register; the back
// keeps working until it has a further message to place, the queue then fills
// and in_i.ready drops.
module pot_to_midi_cc_gate_core import pmcg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  pmcg_in_if.sink           in_i,
  pmcg_out_if.source        out_o
);

  cfg_t  cfg;
  logic  push, full, fifo_valid, pop;
  item_t push_item, head_item;

  pmcg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pmcg_front u_front (
    .in_i   (in_i),
    .cfg_i  (cfg),
    .full_i (full),
    .push_o (push),
    .item_o (push_item)
  );

  pmcg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .valid_o (fifo_valid),
    .item_o  (head_item),
    .pop_i   (pop)
  );

  pmcg_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (fifo_valid),
    .item_i  (head_item),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top import pmcg_pkg::*; ();

  localparam int QuietLimit = 2000;
  localparam int SettleCycles = 40;
  localparam int MaxShown = 10;

  // addresses past the last register, writes there must change nothing
  localparam logic [2:0] RegSpareLo = 3'd6;
  localparam logic [2:0] RegSpareHi = 3'd7;

  typedef struct {
    logic [PotIdxW-1:0] pot;
    logic [SampleW-1:0] smp;
    logic [TimeW-1:0]   now;
  } pot_sample_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [CcW-1:0]     ctrl;
    logic [CcW-1:0]     value;
  } cc_msg_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;
  logic              pready;

  pmcg_in_if  in_if ();
  pmcg_out_if out_if ();

  pot_to_midi_cc_gate_core u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_if),
    .out_o   (out_if)
  );

  always #5 clk_i = ~clk_i;

  // register shadow and per-pot gate state
  cfg_t               cfg_sh;
  cfg_t               next_cfg;
  logic [SampleW-1:0] sent_sample [NumPots];
  logic [CcW-1:0]     sent_value [NumPots];
  logic [TimeW-1:0]   move_stamp [NumPots];

  pot_sample_t        sample_q [$];
  pot_sample_t        next_smp;
  cc_msg_t            msg_due_q [$];
  cc_msg_t            got_msg;
  cc_msg_t            want_msg;

  int                 pot_pos [NumPots];
  logic [TimeW-1:0]   clock_ms;
  int                 n_pushed = 0;
  int                 n_sent = 0;
  int                 n_msgs = 0;
  int                 n_errors = 0;
  int                 n_settings = 0;
  int                 gap_left = 0;
  int                 stall_left = 0;
  int                 idle_cycles = 0;
  bit                 calm_in = 1'b0;
  bit                 calm_out = 1'b0;

  function automatic logic [CcW-1:0] scale_sample(input logic [SampleW-1:0] smp);
    int unsigned num;
    int unsigned den;
    int unsigned quo;
    if (cfg_sh.in_max <= cfg_sh.in_min || smp <= cfg_sh.in_min) return '0;
    num = smp - cfg_sh.in_min;
    den = cfg_sh.in_max - cfg_sh.in_min;
    quo = (num * CcMax) / den;
    if (quo > CcMax) quo = CcMax;
    return CcW'(quo);
  endfunction

  task automatic gate_step(input logic [PotIdxW-1:0] pot, input logic [SampleW-1:0] smp,
                           input logic [TimeW-1:0] now);
    logic [CcW-1:0]     val;
    logic [SampleW-1:0] delta;
    logic [TimeW-1:0]   since;
    cc_msg_t            msg;
    val = scale_sample(smp);
    delta = (smp >= sent_sample[pot]) ? smp - sent_sample[pot] : sent_sample[pot] - smp;
    if (delta > cfg_sh.change_threshold) move_stamp[pot] = now;
    since = now - move_stamp[pot];
    if (since < cfg_sh.hold_ms && val != sent_value[pot]) begin
      msg.status = CcStatus | StatusW'(cfg_sh.midi_channel);
      msg.ctrl = cfg_sh.first_controller + CcW'(pot);
      msg.value = val;
      msg_due_q.push_back(msg);
      sent_sample[pot] = smp;
      sent_value[pot] = val;
    end
  endtask

  task automatic report_mismatch(input string what, input cc_msg_t want, input cc_msg_t got);
    if (n_errors < MaxShown) begin
      $display("tb_top: %s: expected %02h/%0d/%0d, got %02h/%0d/%0d", what,
               want.status, want.ctrl, want.value, got.status, got.ctrl, got.value);
    end
    n_errors++;
  endtask

  task automatic reg_write(input logic [2:0] ridx, input logic [PdataW-1:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {ridx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (ridx)
      RegInMin:     cfg_sh.in_min = val[SampleW-1:0];
      RegInMax:     cfg_sh.in_max = val[SampleW-1:0];
      RegThreshold: cfg_sh.change_threshold = val[SampleW-1:0];
      RegHoldMs:    cfg_sh.hold_ms = val[HoldW-1:0];
      RegChannel:   cfg_sh.midi_channel = val[ChanW-1:0];
      RegFirstCtrl: cfg_sh.first_controller = val[CcW-1:0];
      default: ;
    endcase
  endtask

  // random upper bits check that the block keeps only the register width
  function automatic logic [PdataW-1:0] pad_junk(input logic [PdataW-1:0] v, input int w,
                                                 input bit junk);
    logic [PdataW-1:0] hi;
    hi = $urandom;
    return junk ? (v | (hi << w)) : v;
  endfunction

  task automatic write_cfg(input cfg_t c, input bit junk);
    reg_write(RegInMin, pad_junk(c.in_min, SampleW, junk));
    reg_write(RegInMax, pad_junk(c.in_max, SampleW, junk));
    reg_write(RegThreshold, pad_junk(c.change_threshold, SampleW, junk));
    reg_write(RegHoldMs, pad_junk(c.hold_ms, HoldW, junk));
    reg_write(RegChannel, pad_junk(c.midi_channel, ChanW, junk));
    reg_write(RegFirstCtrl, pad_junk(c.first_controller, CcW, junk));
    n_settings++;
  endtask

  task automatic push_sample(input logic [PotIdxW-1:0] pot, input logic [SampleW-1:0] smp,
                             input logic [TimeW-1:0] now);
    sample_q.push_back('{pot, smp, now});
    n_pushed++;
  endtask

  task automatic wait_drained();
    while (n_sent != n_pushed || msg_due_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // mostly pots that move and settle with time running forward, some noise
  task automatic gen_moves(input int count);
    int k;
    int kind;
    int pot;
    int step;
    calm_in = ($urandom_range(0, 3) == 0);
    calm_out = ($urandom_range(0, 3) == 0);
    for (k = 0; k < count; k++) begin
      kind = $urandom_range(0, 99);
      pot = $urandom_range(0, NumPots - 1);
      clock_ms += $urandom_range(0, 40);
      if (kind < 45) begin
        step = $urandom_range(0, 60);
        pot_pos[pot] += step - 30;
      end else if (kind < 70) begin
        step = $urandom_range(20, 200);
        if ($urandom_range(0, 1) != 0) step = -step;
        pot_pos[pot] += step;
      end else if (kind < 80) begin
        pot_pos[pot] = ($urandom_range(0, 1) != 0) ? 1023 : 0;
      end else if (kind < 90) begin
        // long quiet stretch lets the hold window close
        clock_ms += $urandom_range(100, 5000);
      end else begin
        push_sample(PotIdxW'(pot), SampleW'($urandom), TimeW'($urandom));
        continue;
      end
      if (pot_pos[pot] < 0) pot_pos[pot] = 0;
      if (pot_pos[pot] > 1023) pot_pos[pot] = 1023;
      push_sample(PotIdxW'(pot), SampleW'(pot_pos[pot]), clock_ms);
    end
  endtask

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        gate_step(in_if.pot_index, in_if.sample, in_if.now_ms);
        n_sent++;
        gap_left = calm_in ? 0 : $urandom_range(0, 6);
      end
      if (in_if.valid && !in_if.ready) begin
        // item held until taken
      end else if (gap_left > 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (sample_q.size() > 0) begin
        next_smp = sample_q.pop_front();
        in_if.pot_index <= next_smp.pot;
        in_if.sample <= next_smp.smp;
        in_if.now_ms <= next_smp.now;
        in_if.valid <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got_msg = {out_if.status_byte, out_if.controller_number, out_if.cc_value};
        if (msg_due_q.size() == 0) begin
          report_mismatch("message with none expected", '0, got_msg);
        end else begin
          want_msg = msg_due_q.pop_front();
          if (got_msg.status != want_msg.status || got_msg.ctrl != want_msg.ctrl ||
              got_msg.value != want_msg.value) begin
            report_mismatch("message mismatch", want_msg, got_msg);
          end
        end
        n_msgs++;
        stall_left = calm_out ? 0 : $urandom_range(0, 6);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= QuietLimit) begin
      $display("tb_top: no progress for %0d cycles", QuietLimit);
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    int i;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.pot_index = '0;
    in_if.sample = '0;
    in_if.now_ms = '0;
    out_if.ready = 1'b0;
    cfg_sh = {RstInMin, RstInMax, RstThreshold, RstHoldMs, RstChannel, RstFirstCtrl};
    for (i = 0; i < NumPots; i++) begin
      sent_sample[i] = '0;
      sent_value[i] = '0;
      move_stamp[i] = '0;
      pot_pos[i] = 0;
    end
    clock_ms = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // default settings: first report, still pot, jitter under threshold,
    // window expiry, timestamp wrap, alternating bit patterns
    push_sample(0, 10'd1023, 32'd5);
    push_sample(1, 10'd0, 32'd6);
    push_sample(1, 10'd10, 32'd7);
    push_sample(2, 10'd11, 32'd8);
    push_sample(2, 10'd600, 32'd9);
    push_sample(3, 10'd30, 32'd10);
    push_sample(3, 10'd45, 32'd20);
    push_sample(3, 10'd45, 32'd400);
    push_sample(3, 10'd50, 32'd420);
    push_sample(0, 10'd1000, 32'd30);
    push_sample(4, 10'd512, 32'hFFFF_FFF0);
    push_sample(4, 10'd530, 32'h0000_0010);
    push_sample(5, 10'd1023, 32'hFFFF_FFFF);
    push_sample(6, 10'h2AA, 32'h5555_5555);
    push_sample(7, 10'h155, 32'hAAAA_AAAA);
    push_sample(7, 10'h2AA, 32'hAAAA_AAB0);
    clock_ms = 32'hAAAA_AB00;
    gen_moves(100);
    // let every message come back before sending more
    wait_drained();
    gen_moves(60);
    wait_drained();

    // full range, any change is movement, widest window, top channel,
    // controller numbers wrap
    next_cfg = {10'd0, 10'd1023, 10'd0, 16'hFFFF, 4'hF, 7'd127};
    write_cfg(next_cfg, 1'b1);
    reg_write(RegSpareLo, '1);
    reg_write(RegSpareHi, '1);
    push_sample(7, 10'd1023, clock_ms + 1);
    push_sample(7, 10'd0, clock_ms + 2);
    push_sample(0, 10'd1, clock_ms + 3);
    push_sample(0, 10'd1, clock_ms + 4);
    push_sample(6, 10'd8, clock_ms + 5);
    push_sample(6, 10'd9, clock_ms + 6);
    clock_ms += 10;
    gen_moves(60);
    wait_drained();

    // narrowest range with a closed window: nothing may come out
    next_cfg = {10'd1022, 10'd1023, 10'd1023, 16'd0, 4'd5, 7'd0};
    write_cfg(next_cfg, 1'b0);
    gen_moves(10);
    wait_drained();

    // narrowest range, threshold never exceeded, widest window
    next_cfg = {10'd1022, 10'd1023, 10'd1023, 16'hFFFF, 4'd10, 7'd120};
    write_cfg(next_cfg, 1'b0);
    push_sample(1, 10'd1021, clock_ms + 1);
    push_sample(1, 10'd1022, clock_ms + 2);
    push_sample(1, 10'd1023, clock_ms + 3);
    clock_ms += 5;
    gen_moves(40);
    wait_drained();

    // empty input range, equal bounds and then reversed bounds
    next_cfg = {10'd500, 10'd500, 10'd20, 16'd300, 4'd3, 7'd64};
    write_cfg(next_cfg, 1'b0);
    gen_moves(30);
    wait_drained();
    next_cfg = {10'd1022, 10'd1, 10'd20, 16'd300, 4'd3, 7'd64};
    write_cfg(next_cfg, 1'b0);
    gen_moves(30);
    wait_drained();

    for (i = 0; i < 3; i++) begin
      next_cfg = {SampleW'($urandom_range(0, 400)), SampleW'($urandom_range(500, 1023)),
                  SampleW'($urandom_range(0, 60)), HoldW'($urandom_range(50, 2000)),
                  ChanW'($urandom), CcW'($urandom)};
      write_cfg(next_cfg, 1'b1);
      if (i == 1) clock_ms = 32'hFFFF_F000;
      gen_moves(40);
      wait_drained();
    end

    if (msg_due_q.size() != 0) n_errors++;
    $display("tb_top: %0d samples sent under %0d register settings", n_sent, n_settings);
    $display("tb_top: %0d control-change messages compared, %0d mismatches", n_msgs,
             n_errors);
    if (n_errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
